@@ hdl/sfcm_pkg.sv @@
// shared types, constants and colour stop tables for the scalar false colour mapper
// no dependencies
package sfcm_pkg;

  localparam int PosW    = 17;  // position 0..65536, 16 fraction bits
  localparam int StopCnt = 27;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               sample_invalid;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_t;

  // control bits that travel with each word through the stages
  typedef struct packed {
    logic valid;
    logic invalid;
  } tag_t;

  typedef enum logic [1:0] {
    REG_RANGE_LOW     = 2'd0,
    REG_RANGE_HIGH    = 2'd1,
    REG_RAMP_PRESET   = 2'd2,
    REG_INVALID_COLOR = 2'd3
  } reg_idx_e;

  localparam logic [2:0] PRESET_GRAY   = 3'd0;
  localparam logic [2:0] PRESET_TURBO  = 3'd4;

  localparam logic [15:0] RANGE_HIGH_RST    = 16'h7fff;
  localparam logic [31:0] INVALID_COLOR_RST = 32'hff00ffff;

  localparam logic [4:0] RAMP_FIRST [4] = '{5'd0, 5'd5, 5'd12, 5'd19};
  localparam logic [3:0] RAMP_COUNT [4] = '{4'd5, 4'd7, 4'd7, 4'd8};

  // stop positions as round(h * 65536 / 100)
  localparam logic [PosW-1:0] STOP_POS [StopCnt] = '{
    17'd0, 17'd16384, 17'd32768, 17'd49152, 17'd65536,
    17'd0, 17'd9830, 17'd19661, 17'd29491, 17'd39322, 17'd49152, 17'd65536,
    17'd0, 17'd11141, 17'd22282, 17'd32768, 17'd43909, 17'd55050, 17'd65536,
    17'd0, 17'd9175, 17'd18350, 17'd27525, 17'd36700, 17'd45875, 17'd55050,
    17'd65536
  };

  // stop colours in thousandths
  localparam logic [9:0] STOP_R [StopCnt] = '{
    10'd100, 10'd120, 10'd960, 10'd980, 10'd820,
    10'd267, 10'd283, 10'd254, 10'd207, 10'd128, 10'd267, 10'd993,
    10'd1, 10'd111, 10'd316, 10'd594, 10'd857, 10'd988, 10'd987,
    10'd190, 10'd145, 10'd23, 10'd187, 10'd627, 10'd956, 10'd892, 10'd480
  };
  localparam logic [9:0] STOP_G [StopCnt] = '{
    10'd180, 10'd680, 10'd960, 10'd700, 10'd80,
    10'd5, 10'd141, 10'd265, 10'd372, 10'd567, 10'd749, 10'd906,
    10'd0, 10'd64, 10'd71, 10'd176, 10'd360, 10'd647, 10'd991,
    10'd72, 10'd365, 10'd627, 10'd808, 10'd897, 10'd706, 10'd314, 10'd16
  };
  localparam logic [9:0] STOP_B [StopCnt] = '{
    10'd840, 10'd920, 10'd900, 10'd160, 10'd120,
    10'd329, 10'd458, 10'd530, 10'd553, 10'd551, 10'd441, 10'd144,
    10'd14, 10'd262, 10'd485, 10'd501, 10'd410, 10'd211, 10'd749,
    10'd232, 10'd901, 10'd886, 10'd559, 10'd196, 10'd95, 10'd87, 10'd10
  };

endpackage

@@ hdl/sfcm_position.sv @@
// range normalization: sample to unsigned position with 16 fraction bits
// one setup stage and four restoring divider stages of four bits each; uses sfcm_pkg
module sfcm_position (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  sfcm_pkg::tag_t           tag_i,
  input  logic signed [15:0]       sample_i,
  input  logic signed [15:0]       range_low_i,
  input  logic signed [15:0]       range_high_i,
  output sfcm_pkg::tag_t           tag_o,
  output logic [sfcm_pkg::PosW-1:0] pos_o
);
  import sfcm_pkg::*;

  tag_t              tag_q   [5];
  logic [15:0]       rem_q   [5];
  logic [15:0]       den_q   [5];
  logic [15:0]       quo_q   [5];
  logic              fix_q   [5];
  logic [PosW-1:0]   fixv_q  [5];

  logic signed [17:0] num_s, den_s, num_a, den_a;
  logic               fix_d;
  logic [PosW-1:0]    fixv_d;
  logic [15:0]        rem_d [4];
  logic [15:0]        quo_d [4];

  always_comb begin
    num_s = 18'(sample_i) - 18'(range_low_i);
    den_s = 18'(range_high_i) - 18'(range_low_i);
    if (den_s < 0) begin
      num_a = -num_s;
      den_a = -den_s;
    end else begin
      num_a = num_s;
      den_a = den_s;
    end
    fix_d  = 1'b1;
    fixv_d = '0;
    if (den_s == 0) begin
      fixv_d = PosW'(32768);
    end else if (num_a <= 0) begin
      fixv_d = '0;
    end else if (num_a >= den_a) begin
      fixv_d = PosW'(65536);
    end else begin
      fix_d = 1'b0;
    end
  end

  // four quotient bits per stage
  always_comb begin
    logic [16:0] r2;
    logic [15:0] r;
    logic [15:0] q;
    for (int s = 0; s < 4; s++) begin
      r = rem_q[s];
      q = quo_q[s];
      for (int b = 0; b < 4; b++) begin
        r2 = {r, 1'b0};
        if (r2 >= {1'b0, den_q[s]}) begin
          r = 16'(r2 - {1'b0, den_q[s]});
          q = {q[14:0], 1'b1};
        end else begin
          r = r2[15:0];
          q = {q[14:0], 1'b0};
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 5; s++) tag_q[s] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < 5; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_a[15:0];
      den_q[0]  <= den_a[15:0];
      quo_q[0]  <= '0;
      fix_q[0]  <= fix_d;
      fixv_q[0] <= fixv_d;
      for (int s = 1; s < 5; s++) begin
        rem_q[s]  <= rem_d[s-1];
        den_q[s]  <= den_q[s-1];
        quo_q[s]  <= quo_d[s-1];
        fix_q[s]  <= fix_q[s-1];
        fixv_q[s] <= fixv_q[s-1];
      end
    end
  end

  assign tag_o = tag_q[4];
  assign pos_o = fix_q[4] ? fixv_q[4] : {1'b0, quo_q[4]};

endmodule

@@ hdl/sfcm_colour.sv @@
// position to rgb: segment lookup, blend multiply, scale, two-stage 8-bit divider
// five register stages; uses sfcm_pkg stop tables
module sfcm_colour (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  sfcm_pkg::tag_t            tag_i,
  input  logic [sfcm_pkg::PosW-1:0] pos_i,
  input  logic [2:0]                preset_i,
  output sfcm_pkg::tag_t            tag_o,
  output logic [7:0]                red_o,
  output logic [7:0]                green_o,
  output logic [7:0]                blue_o
);
  import sfcm_pkg::*;

  tag_t tag_q [5];
  logic [7:0] gray_q [5];

  // segment stage
  logic [14:0]       span_q;
  logic [14:0]       dpos_q;
  logic [9:0]        c0_q [3];
  logic signed [10:0] dc_q [3];
  // blend stage
  logic [14:0]       span2_q;
  logic [23:0]       blend_q [3];
  // scale stage and divider
  logic [29:0]       rem_q [3][3];
  logic [21:0]       den_q [3];
  logic [7:0]        quo_q [3][3];

  logic [1:0]        pidx;
  logic [4:0]        first, li, ri;
  logic [3:0]        cnt;
  logic [2:0]        seg;
  logic [PosW-1:0]   tl, tr;
  logic [9:0]        cl [3];
  logic [9:0]        cr [3];
  logic [24:0]       gprod;
  logic signed [27:0] blend_d [3];
  logic [29:0]       rem_d [2][3];
  logic [7:0]        quo_d [2][3];
  logic              is_gray;

  always_comb begin
    pidx  = 2'(preset_i - 3'd1);
    first = RAMP_FIRST[pidx];
    cnt   = RAMP_COUNT[pidx];
    seg   = 3'(cnt - 4'd1);
    // smallest stop index over 0 whose position is not below the word's position
    for (int i = 7; i >= 1; i--) begin
      if (4'(i) < cnt && pos_i <= STOP_POS[first + 5'(i)]) seg = 3'(i);
    end
    ri = first + 5'(seg);
    li = ri - 5'd1;
    tl = STOP_POS[li];
    tr = STOP_POS[ri];
    cl[0] = STOP_R[li]; cr[0] = STOP_R[ri];
    cl[1] = STOP_G[li]; cr[1] = STOP_G[ri];
    cl[2] = STOP_B[li]; cr[2] = STOP_B[ri];
    gprod = 25'(pos_i) * 25'd255 + 25'd32768;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      blend_d[k] = $signed({18'd0, c0_q[k]}) * $signed({13'd0, span_q}) +
                   28'(dc_q[k]) * $signed({13'd0, dpos_q});
    end
  end

  // four quotient bits per divider stage
  always_comb begin
    logic [29:0] r;
    logic [7:0]  q;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < 3; k++) begin
        r = rem_q[s][k];
        q = quo_q[s][k];
        for (int b = 3; b >= 0; b--) begin
          if ({8'd0, r} >= ({16'd0, den_q[s]} << (b + 4 * (1 - s)))) begin
            r = 30'(r - ({8'd0, den_q[s]} << (b + 4 * (1 - s))));
            q[b + 4 * (1 - s)] = 1'b1;
          end
        end
        rem_d[s][k] = r;
        quo_d[s][k] = q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 5; s++) tag_q[s] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < 5; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gray_q[0] <= gprod[23:16];
      for (int s = 1; s < 5; s++) gray_q[s] <= gray_q[s-1];
      span_q <= 15'(tr - tl);
      dpos_q <= 15'(pos_i - tl);
      for (int k = 0; k < 3; k++) begin
        c0_q[k] <= cl[k];
        dc_q[k] <= $signed({1'b0, cr[k]}) - $signed({1'b0, cl[k]});
      end
      span2_q <= span_q;
      for (int k = 0; k < 3; k++) begin
        blend_q[k] <= (blend_d[k] < 0) ? '0 : blend_d[k][23:0];
        rem_q[0][k] <= 30'(blend_q[k]) * 30'd51 + 30'(span2_q) * 30'd100;
        quo_q[0][k] <= '0;
        rem_q[1][k] <= rem_d[0][k];
        quo_q[1][k] <= quo_d[0][k];
        rem_q[2][k] <= rem_d[1][k];
        quo_q[2][k] <= quo_d[1][k];
      end
      den_q[0] <= 22'(span2_q) * 22'd200;
      den_q[1] <= den_q[0];
      den_q[2] <= den_q[1];
    end
  end

  assign is_gray = (preset_i == PRESET_GRAY) || (preset_i > PRESET_TURBO);
  assign tag_o   = tag_q[4];
  assign red_o   = is_gray ? gray_q[4] : quo_q[2][0];
  assign green_o = is_gray ? gray_q[4] : quo_q[2][1];
  assign blue_o  = is_gray ? gray_q[4] : quo_q[2][2];

endmodule

@@ hdl/scalar_false_color_mapper.sv @@
// top level of the scalar false colour mapper: config registers, stage enable,
// output register; uses sfcm_pkg, sfcm_position and sfcm_colour
//
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one sample word
//   (value and invalid flag); output channel out_valid_o / out_stall_i /
//   out_data_o carries one rgba word per sample, in order
//   config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 range low, 1 range high, 2 ramp preset, 3 invalid colour); write only
//   while no word is in flight
//   latency is 11 cycles: one setup stage, four position divider stages,
//   five colour stages and the output register
//   throughput is one word per cycle; all stages share one enable
//   when out_stall_i holds a full output register the whole pipe freezes
//   and in_stall_o rises in the same cycle; nothing is dropped or repeated
//   reset clears all valid bits and loads the register defaults
//   (low 0, high 32767, gray ramp, invalid colour ff00ffff)
module scalar_false_color_mapper (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sfcm_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sfcm_pkg::out_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i
);
  import sfcm_pkg::*;

  logic signed [15:0] range_low_q, range_high_q;
  logic [2:0]         preset_q;
  logic [31:0]        invalid_color_q;

  logic            en;
  tag_t            in_tag, pos_tag, col_tag;
  logic [PosW-1:0] pos;
  logic [7:0]      red, green, blue;
  logic            out_valid_q;
  out_t            out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q     <= '0;
      range_high_q    <= RANGE_HIGH_RST;
      preset_q        <= PRESET_GRAY;
      invalid_color_q <= INVALID_COLOR_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RANGE_LOW:     range_low_q     <= cfg_data_i[15:0];
        REG_RANGE_HIGH:    range_high_q    <= cfg_data_i[15:0];
        REG_RAMP_PRESET:   preset_q        <= cfg_data_i[2:0];
        REG_INVALID_COLOR: invalid_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign in_tag     = '{valid: in_valid_i, invalid: in_data_i.sample_invalid};

  sfcm_position u_position (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .tag_i        (in_tag),
    .sample_i     (in_data_i.sample_value),
    .range_low_i  (range_low_q),
    .range_high_i (range_high_q),
    .tag_o        (pos_tag),
    .pos_o        (pos)
  );

  sfcm_colour u_colour (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .tag_i    (pos_tag),
    .pos_i    (pos),
    .preset_i (preset_q),
    .tag_o    (col_tag),
    .red_o    (red),
    .green_o  (green),
    .blue_o   (blue)
  );

  always_comb begin
    if (col_tag.invalid) begin
      out_d = invalid_color_q;
    end else begin
      out_d = '{red: red, green: green, blue: blue, alpha: 8'hff};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= col_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_flow_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o) else $error("pipe stalled without back pressure");
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("input stalled with empty output");
  a_alpha_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.alpha != 8'hff) |-> (out_data_o == invalid_color_q))
    else $error("partial alpha not from invalid colour");
`endif

endmodule

@@ bench/sfcm_checker.sv @@
// checker for the scalar false colour mapper: watches both channels, predicts each
// rgba word from the register copy and compares in order; uses sfcm_pkg
module sfcm_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  sfcm_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  sfcm_pkg::out_t out_data_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  output int             errors_o,
  output int             pending_o,
  output int             seen_o
);
  import sfcm_pkg::*;

  logic signed [15:0] lo_q, hi_q;
  logic [2:0]         preset_q;
  logic [31:0]        inv_color_q;
  out_t               colour_q[$];

  // stop tables in hundredths and thousandths
  int stop_at [27] = '{0, 25, 50, 75, 100, 0, 15, 30, 45, 60, 75, 100,
                       0, 17, 34, 50, 67, 84, 100, 0, 14, 28, 42, 56, 70, 84, 100};
  int stop_rgb [27][3] = '{
    '{100, 180, 840}, '{120, 680, 920}, '{960, 960, 900}, '{980, 700, 160},
    '{820, 80, 120},
    '{267, 5, 329}, '{283, 141, 458}, '{254, 265, 530}, '{207, 372, 553},
    '{128, 567, 551}, '{267, 749, 441}, '{993, 906, 144},
    '{1, 0, 14}, '{111, 64, 262}, '{316, 71, 485}, '{594, 176, 501},
    '{857, 360, 410}, '{988, 647, 211}, '{987, 991, 749},
    '{190, 72, 232}, '{145, 365, 901}, '{23, 627, 886}, '{187, 808, 559},
    '{627, 897, 196}, '{956, 706, 95}, '{892, 314, 87}, '{480, 16, 10}};
  int ramp_base [4] = '{0, 5, 12, 19};
  int ramp_len [4]  = '{5, 7, 7, 8};

  function automatic longint stop_place(int h);
    return (longint'(h) * 65536 + 50) / 100;
  endfunction

  function automatic longint clip8(longint v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic longint place_of(logic signed [15:0] s);
    longint num, den;
    den = longint'(hi_q) - longint'(lo_q);
    num = longint'(s) - longint'(lo_q);
    if (den == 0) return 32768;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) return 0;
    if (num >= den) return 65536;
    return (num * 65536) / den;
  endfunction

  function automatic out_t colour_of(in_t w);
    out_t c;
    longint p, tl, tr, span, d, num, g;
    int b, n, i;
    longint ch [3];
    if (w.sample_invalid) return out_t'(inv_color_q);
    p = place_of(w.sample_value);
    if (preset_q >= 1 && preset_q <= PRESET_TURBO) begin
      b = ramp_base[preset_q - 1];
      n = ramp_len[preset_q - 1];
      if (p <= stop_place(stop_at[b]) || p >= stop_place(stop_at[b + n - 1])) begin
        i = (p <= stop_place(stop_at[b])) ? b : b + n - 1;
        for (int k = 0; k < 3; k++)
          ch[k] = clip8((longint'(stop_rgb[i][k]) * 510 + 1000) / 2000);
      end else begin
        i = b + 1;
        while (p > stop_place(stop_at[i])) i++;
        tr = stop_place(stop_at[i]);
        tl = stop_place(stop_at[i - 1]);
        span = tr - tl;
        d = 1000 * span;
        for (int k = 0; k < 3; k++) begin
          num = longint'(stop_rgb[i - 1][k]) * span
              + longint'(stop_rgb[i][k] - stop_rgb[i - 1][k]) * (p - tl);
          if (num < 0) num = 0;
          ch[k] = clip8((num * 510 + d) / (2 * d));
        end
      end
    end else begin
      g = clip8((p * 510 + 65536) / 131072);
      ch = '{g, g, g};
    end
    c.red = ch[0][7:0];
    c.green = ch[1][7:0];
    c.blue = ch[2][7:0];
    c.alpha = 8'hff;
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= RANGE_HIGH_RST;
      preset_q <= PRESET_GRAY;
      inv_color_q <= INVALID_COLOR_RST;
      errors_o <= 0;
      seen_o <= 0;
      colour_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) colour_q.push_back(colour_of(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        seen_o <= seen_o + 1;
        if (colour_q.size() == 0) begin
          $error("rgba word with nothing expected: %h", out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = colour_q.pop_front();
          if (want != out_data_i) begin
            errors_o <= errors_o + 1;
            if (want.red != out_data_i.red)
              $error("red: expected %0d got %0d", want.red, out_data_i.red);
            if (want.green != out_data_i.green)
              $error("green: expected %0d got %0d", want.green, out_data_i.green);
            if (want.blue != out_data_i.blue)
              $error("blue: expected %0d got %0d", want.blue, out_data_i.blue);
            if (want.alpha != out_data_i.alpha)
              $error("alpha: expected %0d got %0d", want.alpha, out_data_i.alpha);
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_RANGE_LOW:     lo_q <= cfg_data_i[15:0];
          REG_RANGE_HIGH:    hi_q <= cfg_data_i[15:0];
          REG_RAMP_PRESET:   preset_q <= cfg_data_i[2:0];
          REG_INVALID_COLOR: inv_color_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign pending_o = colour_q.size();
endmodule

@@ bench/tb_top.sv @@
// stimulus and verdict for the scalar false colour mapper: register phases, directed
// and random samples under varying idle and stall; uses sfcm_pkg and sfcm_checker
module tb_top;
  import sfcm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          errors, pending, seen;
  int          send_idle = 0, stall_pct = 0;
  longint      cycles = 0;

  always #10 clk_i = ~clk_i;

  scalar_false_color_mapper DUT (.*);

  sfcm_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .seen_o(seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sends one word, honoring the sender idle rate
  task automatic send_word(logic signed [15:0] v, logic bad);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{sample_value: v, sample_invalid: bad};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_range(logic [15:0] lo, logic [15:0] hi, logic [2:0] p);
    write_reg(REG_RANGE_LOW, {16'h0, lo});
    write_reg(REG_RANGE_HIGH, {16'h0, hi});
    write_reg(REG_RAMP_PRESET, {29'h0, p});
  endtask

  // mostly samples near the range, sometimes anywhere
  function automatic logic [15:0] pick_sample(logic [15:0] lo, logic [15:0] hi);
    int a, b;
    if ($urandom_range(3) == 0) return 16'($urandom);
    a = int'($signed(lo));
    b = int'($signed(hi));
    if (a > b) begin
      int t = a;
      a = b;
      b = t;
    end
    a = (a - 50 < -32768) ? -32768 : a - 50;
    b = (b + 50 > 32767) ? 32767 : b + 50;
    return 16'($urandom_range(b - a) + a);
  endfunction

  initial begin
    logic [15:0] lo, hi;
    logic signed [15:0] dir_vals [8] = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1,
                                         16'sd16384, 16'sd1, 16'sh5555, 16'sh2aaa};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers, then extremes and special ranges
    foreach (dir_vals[i]) send_word(dir_vals[i], 1'b0);
    send_word(16'sd5, 1'b1);
    drain();
    write_reg(REG_INVALID_COLOR, 32'h0000_0000);
    set_range(16'h8000, 16'h7fff, 3'd1);
    foreach (dir_vals[i]) send_word(dir_vals[i], 1'b0);
    send_word(16'sh7fff, 1'b1);
    drain();
    write_reg(REG_INVALID_COLOR, 32'hffff_ffff);
    set_range(16'd100, 16'd100, 3'd7);       // equal ends, unused preset
    send_word(16'sd100, 1'b0);
    send_word(-16'sd9, 1'b1);
    drain();
    set_range(16'h7fff, 16'h8000, 3'd4);     // reversed range
    send_word(16'sh8000, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(16'sh7fff, 1'b0);
    drain();

    // random phases over settings and idle patterns
    for (int ph = 0; ph < 26; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 74; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 74; end
        default: begin send_idle = 17; stall_pct = 17; end
      endcase
      if (ph % 5 == 0) begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end else begin
        lo = 16'($urandom_range(2000));
        hi = lo + 16'($urandom_range(3000));
      end
      set_range(lo, hi, 3'(ph % 8));
      write_reg(REG_INVALID_COLOR, $urandom);
      for (int n = 0; n < 75; n++) begin
        send_word(pick_sample(lo, hi), ($urandom_range(9) == 0));
        if (ph == 7 && n == 40) drain();
      end
      drain();
    end
    stall_pct = 0;
    repeat (20) @(posedge clk_i);

    $display("covered %0d rgba words over all presets, reversed, equal and full ranges",
             seen);
    $display("with sender idle, receiver stall and invalid samples mixed in");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
